FILE: sv/char_lcd_write_sequencer_assert.svh
// assertion macros for the character lcd write sequencer
`ifndef CHAR_LCD_WRITE_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_WRITE_SEQUENCER_ASSERT_SVH
`ifndef SYNTH
`define CLCD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("char lcd sequencer check failed");
`define CLCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("char lcd sequencer check failed");
`else
`define CLCD_ASSERT(lbl, clk, rst_n, prop)
`define CLCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/clcd_pkg.sv
// types, codes and start-up commands of the character lcd write sequencer
`default_nettype none
package clcd_pkg;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_EN_HIGH = 3'd1,
		PH_EN_LOW  = 3'd2,
		PH_SETTLE  = 3'd3,
		PH_LOAD    = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		CFG_ENABLE_TICKS = 2'd0,
		CFG_SETTLE_TICKS = 2'd1,
		CFG_BUS_8BIT     = 2'd2
	} cfg_reg_t;

	localparam logic [7:0] CMD_HOME       = 8'h02;
	localparam logic [7:0] CMD_FUNC_4BIT  = 8'h28;
	localparam logic [7:0] CMD_FUNC_8BIT  = 8'h38;
	localparam logic [7:0] CMD_CLEAR      = 8'h01;
	localparam logic [7:0] CMD_DISPLAY_ON = 8'h0C;
	localparam logic [2:0] STARTUP_COUNT  = 3'd4;

	typedef struct packed {
		logic       mode;
		logic       is_data;
		logic [7:0] byte_value;
	} req_t;

	typedef struct packed {
		logic       rs_pin;
		logic       rw_pin;
		logic       en_pin;
		logic [7:0] bus_out;
		logic       busy_res;
		logic       rejected;
	} rsp_t;

	typedef struct packed {
		logic [15:0] enable_ticks;
		logic [15:0] settle_ticks;
		logic        bus_8bit;
	} cfg_t;

	typedef struct packed {
		phase_t     phase;
		logic       second_nibble;
		logic [7:0] held_byte;
		logic       held_rs;
		logic [2:0] startup_index;
		logic [7:0] bus_reg;
	} ctl_t;

	function automatic logic [7:0] startup_cmd(input logic [2:0] idx, input logic bus_8bit);
		logic [7:0] cmd;
		case (idx)
			3'd0: cmd = CMD_HOME;
			3'd1: cmd = bus_8bit ? CMD_FUNC_8BIT : CMD_FUNC_4BIT;
			3'd2: cmd = CMD_CLEAR;
			default: cmd = CMD_DISPLAY_ON;
		endcase
		return cmd;
	endfunction

endpackage
`default_nettype wire

FILE: sv/char_lcd_write_sequencer.sv
// top level of the character lcd write sequencer
`default_nettype none
// Character LCD write sequencer. Each word on req is either one time tick (mode 0)
// or a write request (mode 1); every word gives exactly one rsp word with the pin
// levels after it. From reset the block sends the start-up commands by itself as
// ticks arrive, then waits settle_ticks ticks. Requests that come while busy are
// dropped with rejected set. Throughput is one word per clock while rsp is not
// stalled; each word passes the input register and the result register, with the
// state update done in one pass between them. req_stall rises only while a held
// result is stalled on rsp. Configuration writes take effect at the next edge.
module char_lcd_write_sequencer #(
	parameter int TICK_COUNTER_WIDTH = 16
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_we,
	input  wire [1:0]            cfg_index,
	input  wire [15:0]           cfg_data,
	input  wire                  req_valid,
	output logic                 req_stall,
	input  wire clcd_pkg::req_t  req,
	output logic                 rsp_valid,
	input  wire                  rsp_stall,
	output clcd_pkg::rsp_t       rsp
);

	clcd_pkg::cfg_t                cfg_q;
	clcd_pkg::ctl_t                st_q;
	clcd_pkg::ctl_t                st_nx;
	logic [TICK_COUNTER_WIDTH-1:0] cnt_q;
	logic [TICK_COUNTER_WIDTH-1:0] cnt_nx;
	logic                          valid_s1;
	clcd_pkg::req_t                req_s1;
	clcd_pkg::rsp_t                rsp_nx;
	clcd_pkg::rsp_t                rsp_q;
	logic                          rsp_valid_q;
	logic                          advance;

	assign advance   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable_ticks <= 16'd1000;
			cfg_q.settle_ticks <= 16'd20000;
			cfg_q.bus_8bit     <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				clcd_pkg::CFG_ENABLE_TICKS: cfg_q.enable_ticks <= cfg_data;
				clcd_pkg::CFG_SETTLE_TICKS: cfg_q.settle_ticks <= cfg_data;
				clcd_pkg::CFG_BUS_8BIT:     cfg_q.bus_8bit     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_valid && !req_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
	end

	clcd_step #(
		.TICK_COUNTER_WIDTH(TICK_COUNTER_WIDTH)
	) u_step (
		.st     (st_q),
		.cnt    (cnt_q),
		.cfg    (cfg_q),
		.req    (req_s1),
		.st_nx  (st_nx),
		.cnt_nx (cnt_nx),
		.rsp    (rsp_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase         <= clcd_pkg::PH_LOAD;
			st_q.second_nibble <= 1'b0;
			st_q.held_byte     <= clcd_pkg::CMD_HOME;
			st_q.held_rs       <= 1'b0;
			st_q.startup_index <= 3'd0;
			st_q.bus_reg       <= 8'h00;
			cnt_q              <= '0;
		end else if (advance) begin
			st_q  <= st_nx;
			cnt_q <= cnt_nx;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_nx;
		end
	end

`include "char_lcd_write_sequencer_assert.svh"

	`CLCD_ASSERT(a_en_busy, clk, arst_n, rsp_valid_q && rsp_q.en_pin |-> rsp_q.busy_res)
	`CLCD_ASSERT(a_rej_busy, clk, arst_n, rsp_valid_q && rsp_q.rejected |-> rsp_q.busy_res)
	`CLCD_ASSERT(a_settle_done, clk, arst_n, st_q.phase == clcd_pkg::PH_SETTLE |-> st_q.startup_index == clcd_pkg::STARTUP_COUNT)
	`CLCD_ASSERT_NEXT(a_adv_result, clk, arst_n, advance, rsp_valid_q)

endmodule
`default_nettype wire

FILE: sv/clcd_step.sv
// next-state and pin logic for one tick or write request
`default_nettype none
module clcd_step #(
	parameter int TICK_COUNTER_WIDTH = 16
) (
	input  wire clcd_pkg::ctl_t              st,
	input  wire [TICK_COUNTER_WIDTH-1:0]     cnt,
	input  wire clcd_pkg::cfg_t              cfg,
	input  wire clcd_pkg::req_t              req,
	output clcd_pkg::ctl_t                   st_nx,
	output logic [TICK_COUNTER_WIDTH-1:0]    cnt_nx,
	output clcd_pkg::rsp_t                   rsp
);

	localparam int CW = (TICK_COUNTER_WIDTH > 16) ? TICK_COUNTER_WIDTH : 16;
	localparam logic [TICK_COUNTER_WIDTH-1:0] CNT_MAX = {TICK_COUNTER_WIDTH{1'b1}};

	logic [TICK_COUNTER_WIDTH-1:0] cnt_inc;
	logic                          cnt_at_max;
	logic                          done_en;
	logic                          done_settle;
	logic                          rej;

	// saturating counter; hitting the top also ends a wait
	assign cnt_inc     = (cnt == CNT_MAX) ? cnt : cnt + 1'b1;
	assign cnt_at_max  = (cnt_inc == CNT_MAX);
	assign done_en     = (CW'(cnt_inc) >= CW'(cfg.enable_ticks)) || cnt_at_max;
	assign done_settle = (CW'(cnt_inc) >= CW'(cfg.settle_ticks)) || cnt_at_max;

	always_comb begin
		st_nx  = st;
		cnt_nx = cnt;
		rej    = 1'b0;
		if (req.mode) begin
			if (st.phase != clcd_pkg::PH_IDLE) begin
				rej = 1'b1;
			end else begin
				st_nx.held_byte     = req.byte_value;
				st_nx.held_rs       = req.is_data;
				st_nx.second_nibble = 1'b0;
				st_nx.bus_reg       = cfg.bus_8bit ? req.byte_value
				                                   : {req.byte_value[7:4], 4'h0};
				cnt_nx              = '0;
				st_nx.phase         = clcd_pkg::PH_EN_HIGH;
			end
		end else begin
			case (st.phase)
				clcd_pkg::PH_LOAD: begin
					st_nx.second_nibble = 1'b0;
					st_nx.bus_reg       = cfg.bus_8bit ? st.held_byte
					                                   : {st.held_byte[7:4], 4'h0};
					cnt_nx              = '0;
					st_nx.phase         = clcd_pkg::PH_EN_HIGH;
				end
				clcd_pkg::PH_EN_HIGH: begin
					cnt_nx = cnt_inc;
					if (done_en) begin
						cnt_nx      = '0;
						st_nx.phase = clcd_pkg::PH_EN_LOW;
					end
				end
				clcd_pkg::PH_EN_LOW: begin
					cnt_nx = cnt_inc;
					if (done_en) begin
						cnt_nx = '0;
						if (!cfg.bus_8bit && !st.second_nibble) begin
							// low nibble goes out on the upper bus lines
							st_nx.second_nibble = 1'b1;
							st_nx.bus_reg       = {st.held_byte[3:0], 4'h0};
							st_nx.phase         = clcd_pkg::PH_EN_HIGH;
						end else if (st.startup_index < clcd_pkg::STARTUP_COUNT) begin
							st_nx.startup_index = st.startup_index + 3'd1;
							if (st.startup_index + 3'd1 >= clcd_pkg::STARTUP_COUNT) begin
								st_nx.phase = (cfg.settle_ticks == 16'd0) ? clcd_pkg::PH_IDLE
								                                         : clcd_pkg::PH_SETTLE;
							end else begin
								st_nx.held_byte = clcd_pkg::startup_cmd(st.startup_index + 3'd1,
								                                        cfg.bus_8bit);
								st_nx.held_rs   = 1'b0;
								st_nx.phase     = clcd_pkg::PH_LOAD;
							end
						end else begin
							st_nx.phase = clcd_pkg::PH_IDLE;
						end
					end
				end
				clcd_pkg::PH_SETTLE: begin
					cnt_nx = cnt_inc;
					if (done_settle) begin
						cnt_nx      = '0;
						st_nx.phase = clcd_pkg::PH_IDLE;
					end
				end
				default: begin
					st_nx.phase = clcd_pkg::PH_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		rsp.rs_pin   = st_nx.held_rs;
		rsp.rw_pin   = 1'b0;
		rsp.en_pin   = (st_nx.phase == clcd_pkg::PH_EN_HIGH);
		rsp.bus_out  = st_nx.bus_reg;
		rsp.busy_res = (st_nx.phase != clcd_pkg::PH_IDLE);
		rsp.rejected = rej;
	end

endmodule
`default_nettype wire

FILE: sim/tb_char_lcd_write_sequencer.sv
// testbench for the character lcd write sequencer: queued words, pin predictor, scoreboard
`timescale 1ns / 1ps

module tb_char_lcd_write_sequencer;

	localparam logic [15:0] TICK_MAX = 16'hFFFF;
	localparam int CYCLE_LIMIT = 200_000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	clcd_pkg::cfg_reg_t cfg_index = clcd_pkg::CFG_ENABLE_TICKS;
	logic [15:0] cfg_data = '0;
	logic req_valid = 1'b0;
	logic req_stall;
	clcd_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	clcd_pkg::rsp_t rsp;

	char_lcd_write_sequencer #(.TICK_COUNTER_WIDTH(16)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #10 clk = ~clk;

	// predicted sequencer state and register copy
	clcd_pkg::phase_t ph;
	logic [15:0] tick_cnt;
	logic second_nib;
	logic [7:0] held_byte;
	logic held_rs;
	logic [2:0] boot_idx;
	logic [7:0] bus_reg;
	logic [15:0] cfg_en;
	logic [15:0] cfg_settle;
	logic cfg_8bit;

	clcd_pkg::req_t word_q[$];
	clcd_pkg::rsp_t pending_pins[$];
	int in_flight = 0;
	int words_sent = 0;
	int errors = 0;
	int cycle_count = 0;
	int send_gap = 0;
	int hold_left = 0;
	bit word_taken = 1'b0;
	bit calm = 1'b0;

	function automatic int draw_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// saturating tick count, true once the wait is over
	function automatic logic count_up(input logic [15:0] limit);
		if (tick_cnt != TICK_MAX)
			tick_cnt = tick_cnt + 16'd1;
		return (tick_cnt >= limit) || (tick_cnt == TICK_MAX);
	endfunction

	function automatic void load_byte();
		second_nib = 1'b0;
		bus_reg = cfg_8bit ? held_byte : {held_byte[7:4], 4'h0};
		tick_cnt = '0;
		ph = clcd_pkg::PH_EN_HIGH;
	endfunction

	function automatic clcd_pkg::rsp_t pins_after(input clcd_pkg::req_t w);
		clcd_pkg::rsp_t r;
		r.rejected = 1'b0;
		if (w.mode) begin
			if (ph != clcd_pkg::PH_IDLE) begin
				r.rejected = 1'b1;
			end else begin
				held_byte = w.byte_value;
				held_rs = w.is_data;
				load_byte();
			end
		end else begin
			case (ph)
				clcd_pkg::PH_LOAD: load_byte();
				clcd_pkg::PH_EN_HIGH: begin
					if (count_up(cfg_en)) begin
						tick_cnt = '0;
						ph = clcd_pkg::PH_EN_LOW;
					end
				end
				clcd_pkg::PH_EN_LOW: begin
					if (count_up(cfg_en)) begin
						tick_cnt = '0;
						if (!cfg_8bit && !second_nib) begin
							second_nib = 1'b1;
							bus_reg = {held_byte[3:0], 4'h0};
							ph = clcd_pkg::PH_EN_HIGH;
						end else if (boot_idx < clcd_pkg::STARTUP_COUNT) begin
							boot_idx = boot_idx + 3'd1;
							if (boot_idx >= clcd_pkg::STARTUP_COUNT) begin
								ph = (cfg_settle == 16'd0) ? clcd_pkg::PH_IDLE
								                           : clcd_pkg::PH_SETTLE;
							end else begin
								// next start-up command, function set picks the bus width now
								case (boot_idx)
									3'd1: held_byte = cfg_8bit ? clcd_pkg::CMD_FUNC_8BIT
									                           : clcd_pkg::CMD_FUNC_4BIT;
									3'd2: held_byte = clcd_pkg::CMD_CLEAR;
									default: held_byte = clcd_pkg::CMD_DISPLAY_ON;
								endcase
								held_rs = 1'b0;
								ph = clcd_pkg::PH_LOAD;
							end
						end else begin
							ph = clcd_pkg::PH_IDLE;
						end
					end
				end
				clcd_pkg::PH_SETTLE: begin
					if (count_up(cfg_settle)) begin
						tick_cnt = '0;
						ph = clcd_pkg::PH_IDLE;
					end
				end
				default: ph = clcd_pkg::PH_IDLE;
			endcase
		end
		r.rs_pin = held_rs;
		r.rw_pin = 1'b0;
		r.en_pin = (ph == clcd_pkg::PH_EN_HIGH);
		r.bus_out = bus_reg;
		r.busy_res = (ph != clcd_pkg::PH_IDLE);
		return r;
	endfunction

	task automatic write_reg(input clcd_pkg::cfg_reg_t idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send_word(input logic mode, input logic is_data, input logic [7:0] b);
		clcd_pkg::req_t w;
		w.mode = mode;
		w.is_data = is_data;
		w.byte_value = b;
		word_q.push_back(w);
		in_flight++;
		words_sent++;
	endtask

	task automatic push_ticks(input int n);
		repeat (n) send_word(1'b0, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
	endtask

	task automatic drain();
		while (in_flight != 0 || pending_pins.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// keep ticking until the predicted block is idle
	task automatic run_out();
		while (ph != clcd_pkg::PH_IDLE) begin
			@(posedge clk);
			push_ticks(1);
			while (in_flight != 0)
				@(negedge clk);
		end
		drain();
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// driver: next word goes out at the falling edge once the current one is taken
	always @(negedge clk) begin
		if (arst_n && (!req_valid || word_taken)) begin
			if (send_gap != 0) begin
				send_gap <= send_gap - 1;
				req_valid <= 1'b0;
			end else if (word_q.size() != 0) begin
				req <= word_q.pop_front();
				req_valid <= 1'b1;
				send_gap <= draw_gap();
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
			hold_left <= draw_gap();
		end
	end

	always @(posedge clk) begin : watch
		clcd_pkg::rsp_t want;
		word_taken = arst_n && req_valid && !req_stall;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					clcd_pkg::CFG_ENABLE_TICKS: cfg_en = cfg_data;
					clcd_pkg::CFG_SETTLE_TICKS: cfg_settle = cfg_data;
					clcd_pkg::CFG_BUS_8BIT: cfg_8bit = cfg_data[0];
					default: ;
				endcase
			end
			if (word_taken) begin
				pending_pins.push_back(pins_after(req));
				in_flight--;
			end
			if (rsp_valid && !rsp_stall) begin
				if (pending_pins.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("cycle %0d: result word with nothing expected", cycle_count);
				end else begin
					want = pending_pins.pop_front();
					if (rsp.rs_pin !== want.rs_pin || rsp.rw_pin !== want.rw_pin ||
							rsp.en_pin !== want.en_pin || rsp.bus_out !== want.bus_out ||
							rsp.busy_res !== want.busy_res || rsp.rejected !== want.rejected) begin
						errors++;
						if (errors <= 10)
							$display("cycle %0d: want rs=%b rw=%b en=%b bus=%h busy=%b rej=%b,",
								cycle_count, want.rs_pin, want.rw_pin, want.en_pin,
								want.bus_out, want.busy_res, want.rejected,
								" got rs=%b rw=%b en=%b bus=%h busy=%b rej=%b",
								rsp.rs_pin, rsp.rw_pin, rsp.en_pin, rsp.bus_out,
								rsp.busy_res, rsp.rejected);
					end
				end
			end
		end
	end

	initial begin
		int kind;
		int span;
		int base;
		int pick;
		logic [15:0] en_pick;

		ph = clcd_pkg::PH_LOAD;
		tick_cnt = '0;
		second_nib = 1'b0;
		held_byte = clcd_pkg::CMD_HOME;
		held_rs = 1'b0;
		boot_idx = '0;
		bus_reg = '0;
		cfg_en = 16'd1000;
		cfg_settle = 16'd20000;
		cfg_8bit = 1'b0;

		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// start-up with zero enable time and no settle wait
		write_reg(clcd_pkg::CFG_ENABLE_TICKS, 16'd0);
		write_reg(clcd_pkg::CFG_SETTLE_TICKS, 16'd0);
		write_reg(clcd_pkg::CFG_BUS_8BIT, 16'd0);
		@(posedge clk);
		push_ticks(1);
		send_word(1'b1, 1'b1, 8'hFF);
		push_ticks(2);
		drain();
		// bus width flips in the middle of the first start-up command
		write_reg(clcd_pkg::CFG_BUS_8BIT, 16'd1);
		run_out();

		@(posedge clk);
		push_ticks(1);
		send_word(1'b1, 1'b0, 8'h00);
		push_ticks(2);
		send_word(1'b1, 1'b1, 8'hFF);
		push_ticks(1);
		run_out();

		write_reg(clcd_pkg::CFG_BUS_8BIT, 16'd0);
		write_reg(clcd_pkg::CFG_ENABLE_TICKS, 16'd2);
		@(posedge clk);
		send_word(1'b1, 1'b0, 8'hA5);
		send_word(1'b1, 1'b1, 8'h5A);
		push_ticks(3);
		run_out();
		@(posedge clk);
		send_word(1'b1, 1'b1, 8'h0F);
		push_ticks(8);
		push_ticks(2);
		drain();

		base = words_sent;
		while (words_sent - base < 450) begin
			drain();
			pick = $urandom_range(0, 9);
			if (pick < 6)
				en_pick = 16'($urandom_range(0, 3));
			else if (pick < 9)
				en_pick = 16'($urandom_range(4, 12));
			else
				en_pick = 16'd1;
			write_reg(clcd_pkg::CFG_ENABLE_TICKS, en_pick);
			if ($urandom_range(0, 1))
				write_reg(clcd_pkg::CFG_BUS_8BIT, 16'($urandom_range(0, 1)));
			if ($urandom_range(0, 7) == 0)
				write_reg(clcd_pkg::CFG_SETTLE_TICKS, 16'($urandom_range(0, 65535)));
			calm = ($urandom_range(0, 4) == 0);
			span = (cfg_8bit ? 2 : 4) * ((cfg_en == 16'd0) ? 1 : int'(cfg_en));
			@(posedge clk);
			repeat ($urandom_range(3, 8)) begin
				kind = $urandom_range(0, 9);
				if (kind == 0) begin
					push_ticks($urandom_range(1, 3));
				end else if (kind == 1) begin
					send_word(1'b1, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
				end else begin
					send_word(1'b1, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
					if (kind == 2)
						push_ticks(span - $urandom_range(1, span));
					else if (kind == 3)
						push_ticks(span + $urandom_range(1, 3));
					else
						push_ticks(span);
				end
			end
		end
		drain();
		calm = 1'b0;
		run_out();
		@(posedge clk);
		push_ticks(2);
		drain();

		if (errors == 0 && pending_pins.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
